>>> rtl/rpm_pkg.sv
`default_nettype none

package rpm_pkg;

  // pipeline stage map
  localparam int ST_IN   = 0;
  localparam int ST_SQ   = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_LZ   = 3;
  localparam int ST_SH   = 4;
  localparam int RT_N    = 32;
  localparam int ST_RT0  = 5;
  localparam int ST_DVD  = ST_RT0 + RT_N;
  localparam int DV_N    = 31;
  localparam int ST_DV0  = ST_DVD + 1;
  localparam int ST_SGN  = ST_DV0 + DV_N;
  localparam int ST_MUL1 = ST_SGN + 1;
  localparam int ST_DOT  = ST_MUL1 + 1;
  localparam int ST_QR   = ST_DOT + 1;
  localparam int ST_MUL2 = ST_QR + 1;
  localparam int ST_NUM  = ST_MUL2 + 1;
  localparam int ST_SAT  = ST_NUM + 1;
  localparam int TD_N    = 33;
  localparam int ST_TD0  = ST_SAT + 1;
  localparam int ST_T    = ST_TD0 + TD_N;
  localparam int ST_MUL3 = ST_T + 1;
  localparam int ST_S    = ST_MUL3 + 1;
  localparam int ST_MUL4 = ST_S + 1;
  localparam int ST_MID  = ST_MUL4 + 1;
  localparam int NST     = ST_MID + 1;

  // dot product slots
  localparam int DOT_AB = 0;
  localparam int DOT_CB = 1;
  localparam int DOT_AD = 2;
  localparam int DOT_CD = 3;
  localparam int DOT_BD = 4;

  localparam logic signed [71:0] PMAX     = (72'sd1 <<< 33) - 72'sd1;
  localparam logic signed [71:0] UNIT_ONE = 72'sd1 <<< 30;
  localparam logic signed [71:0] POS_MAX  = 72'sd2147483647;
  localparam logic signed [71:0] NEG_MIN  = -72'sd2147483648;

  typedef struct packed {
    logic [2:0][31:0] dir;
    logic [2:0]       neg;
    logic [2:0][31:0] mg;
    logic [2:0][63:0] sq;
    logic [63:0]      x;
    logic             zero;
    logic [4:0]       k;
    logic [63:0]      res;
    logic [2:0][32:0] rem;
    logic [2:0][30:0] dvd;
    logic [2:0][30:0] quo;
    logic [2:0][31:0] u;
  } ray_t;

  typedef struct packed {
    logic [2:0][31:0]      a;
    logic [2:0][31:0]      c;
    ray_t [1:0]            ray;
    logic [4:0][2:0][63:0] prod;
    logic [4:0][35:0]      dot;
    logic [34:0]           qv;
    logic [34:0]           rv;
    logic [31:0]           bd;
    logic [63:0]           bd2;
    logic [66:0]           qbd;
    logic [60:0]           den;
    logic [35:0]           num;
    logic                  par;
    logic [61:0]           trem;
    logic                  tsat;
    logic                  tneg;
    logic [32:0]           tquo;
    logic [34:0]           tv;
    logic [34:0]           sv;
    logic [66:0]           bdt;
    logic [2:0][66:0]      sb;
    logic [2:0][66:0]      td;
    logic [2:0][31:0]      mid;
    logic                  deg;
  } pipe_t;

endpackage

`default_nettype wire

>>> rtl/ray_pair_midpoint_unit.sv
// Midpoint triangulation of two rays, signed Q16.16 at the ports.
// Input channel: in_valid_i / in_stall_o with twelve 32-bit fields (origin and
// direction of each ray). Output channel: out_valid_o / out_stall_i with
// mid_x/y/z and degenerate. A word moves on an edge with valid high, stall low.
// Throughput: one word per cycle while the output is not stalled. Depth is set
// by the 32-step square root, the 31-step unit-vector dividers and the 33-step
// ray-parameter divider, one step per stage.
// Stall: the whole pipe holds while the final stage carries a word that the
// receiver stalls; in_stall_o is high for exactly those cycles.
// Reset clears every stage valid bit; no word is left in flight.
// Zero-length direction or parallel rays give degenerate = 1 and zero output.
`default_nettype none

module ray_pair_midpoint_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] first_origin_x_i,
  input  wire logic [31:0] first_origin_y_i,
  input  wire logic [31:0] first_origin_z_i,
  input  wire logic [31:0] first_dir_x_i,
  input  wire logic [31:0] first_dir_y_i,
  input  wire logic [31:0] first_dir_z_i,
  input  wire logic [31:0] second_origin_x_i,
  input  wire logic [31:0] second_origin_y_i,
  input  wire logic [31:0] second_origin_z_i,
  input  wire logic [31:0] second_dir_x_i,
  input  wire logic [31:0] second_dir_y_i,
  input  wire logic [31:0] second_dir_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      mid_x_o,
  output logic [31:0]      mid_y_o,
  output logic [31:0]      mid_z_o,
  output logic             degenerate_o
);
  import rpm_pkg::*;

  pipe_t            stg_d [NST];
  pipe_t            stg_q [NST];
  logic [NST-1:0]   vld_q;
  logic             en;

  // round half away from zero of x / 2^n
  function automatic logic [71:0] rnd_shr(input logic [71:0] x, input int n);
    logic [71:0] m;
    logic [71:0] r;
    m = x[71] ? (~x + 72'd1) : x;
    r = (m + (72'd1 << (n - 1))) >> n;
    return x[71] ? (~r + 72'd1) : r;
  endfunction

  function automatic logic [71:0] clamp_s(input logic signed [71:0] x,
                                          input logic signed [71:0] lim);
    logic signed [71:0] r;
    r = x;
    if (x > lim) r = lim;
    if (x < -lim) r = -lim;
    return r;
  endfunction

  function automatic logic [71:0] mul36(input logic [35:0] x, input logic [35:0] y);
    logic signed [71:0] xs;
    logic signed [71:0] ys;
    xs = 72'($signed(x));
    ys = 72'($signed(y));
    return 72'(xs * ys);
  endfunction

  assign en         = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o = !en;

  for (genvar i = 0; i < NST; i++) begin : g_st
    if (i == ST_IN) begin : g_in
      always_comb begin
        stg_d[i]             = '0;
        stg_d[i].a[0]        = first_origin_x_i;
        stg_d[i].a[1]        = first_origin_y_i;
        stg_d[i].a[2]        = first_origin_z_i;
        stg_d[i].c[0]        = second_origin_x_i;
        stg_d[i].c[1]        = second_origin_y_i;
        stg_d[i].c[2]        = second_origin_z_i;
        stg_d[i].ray[0].dir[0] = first_dir_x_i;
        stg_d[i].ray[0].dir[1] = first_dir_y_i;
        stg_d[i].ray[0].dir[2] = first_dir_z_i;
        stg_d[i].ray[1].dir[0] = second_dir_x_i;
        stg_d[i].ray[1].dir[1] = second_dir_y_i;
        stg_d[i].ray[1].dir[2] = second_dir_z_i;
      end
    end else begin : g_wk
      // step numbers, held at 0 outside their own stages
      localparam int RI = (i >= ST_RT0 && i < ST_RT0 + RT_N) ? i - ST_RT0 : 0;
      localparam int DI = (i >= ST_DV0 && i < ST_DV0 + DV_N) ? i - ST_DV0 : 0;
      localparam int TI = (i >= ST_TD0 && i < ST_TD0 + TD_N) ? i - ST_TD0 : 0;
      always_comb begin
        logic [71:0] t72;
        logic [71:0] h;
        logic [63:0] bitv;
        logic [32:0] tr33;
        logic [62:0] dd;
        logic [61:0] tr62;
        logic [35:0] nm;
        logic [33:0] qq;
        logic        rb;
        t72  = '0;
        h    = '0;
        bitv = '0;
        tr33 = '0;
        dd   = '0;
        tr62 = '0;
        nm   = '0;
        qq   = '0;
        rb   = 1'b0;
        stg_d[i] = stg_q[i-1];
        for (int r = 0; r < 2; r++) begin
          for (int j = 0; j < 3; j++) begin
            if (i == ST_SQ) begin
              stg_d[i].ray[r].neg[j] = stg_q[i-1].ray[r].dir[j][31];
              stg_d[i].ray[r].mg[j]  = stg_q[i-1].ray[r].dir[j][31] ?
                                       (~stg_q[i-1].ray[r].dir[j] + 32'd1) :
                                       stg_q[i-1].ray[r].dir[j];
              stg_d[i].ray[r].sq[j]  = {32'd0, stg_d[i].ray[r].mg[j]} *
                                       {32'd0, stg_d[i].ray[r].mg[j]};
            end
            if (i == ST_SH) begin
              stg_d[i].ray[r].mg[j] = stg_q[i-1].ray[r].mg[j] << stg_q[i-1].ray[r].k;
            end
            if (i == ST_DVD) begin
              dd = {1'b0, stg_q[i-1].ray[r].mg[j], 30'd0} +
                   63'(stg_q[i-1].ray[r].res[31:1]);
              stg_d[i].ray[r].rem[j] = {1'b0, dd[62:31]};
              stg_d[i].ray[r].dvd[j] = dd[30:0];
              stg_d[i].ray[r].quo[j] = '0;
            end
            if (i >= ST_DV0 && i < ST_DV0 + DV_N) begin
              tr33 = {stg_q[i-1].ray[r].rem[j][31:0], stg_q[i-1].ray[r].dvd[j][30-DI]};
              if (tr33 >= {1'b0, stg_q[i-1].ray[r].res[31:0]}) begin
                stg_d[i].ray[r].rem[j] = tr33 - {1'b0, stg_q[i-1].ray[r].res[31:0]};
                stg_d[i].ray[r].quo[j][30-DI] = 1'b1;
              end else begin
                stg_d[i].ray[r].rem[j] = tr33;
              end
            end
            if (i == ST_SGN) begin
              stg_d[i].ray[r].u[j] = stg_q[i-1].ray[r].neg[j] ?
                                     (~{1'b0, stg_q[i-1].ray[r].quo[j]} + 32'd1) :
                                     {1'b0, stg_q[i-1].ray[r].quo[j]};
            end
          end
          if (i == ST_SUM) begin
            stg_d[i].ray[r].x    = stg_q[i-1].ray[r].sq[0] + stg_q[i-1].ray[r].sq[1] +
                                   stg_q[i-1].ray[r].sq[2];
            stg_d[i].ray[r].zero = (stg_d[i].ray[r].x == 64'd0);
          end
          if (i == ST_LZ) begin
            stg_d[i].ray[r].k = '0;
            for (int kk = 31; kk >= 0; kk--) begin
              if (stg_q[i-1].ray[r].x[63-2*kk] || stg_q[i-1].ray[r].x[62-2*kk])
                stg_d[i].ray[r].k = 5'(kk);
            end
          end
          if (i == ST_SH) begin
            stg_d[i].ray[r].x   = stg_q[i-1].ray[r].x << {stg_q[i-1].ray[r].k, 1'b0};
            stg_d[i].ray[r].res = '0;
          end
          if (i >= ST_RT0 && i < ST_RT0 + RT_N) begin
            // one result bit per stage
            bitv = 64'd1 << (62 - 2 * RI);
            if (stg_q[i-1].ray[r].x >= stg_q[i-1].ray[r].res + bitv) begin
              stg_d[i].ray[r].x   = stg_q[i-1].ray[r].x - (stg_q[i-1].ray[r].res + bitv);
              stg_d[i].ray[r].res = (stg_q[i-1].ray[r].res >> 1) + bitv;
            end else begin
              stg_d[i].ray[r].res = stg_q[i-1].ray[r].res >> 1;
            end
          end
        end
        if (i == ST_MUL1) begin
          for (int j = 0; j < 3; j++) begin
            stg_d[i].prod[DOT_AB][j] = 64'(mul36(36'($signed(stg_q[i-1].a[j])),
                                         36'($signed(stg_q[i-1].ray[0].u[j]))));
            stg_d[i].prod[DOT_CB][j] = 64'(mul36(36'($signed(stg_q[i-1].c[j])),
                                         36'($signed(stg_q[i-1].ray[0].u[j]))));
            stg_d[i].prod[DOT_AD][j] = 64'(mul36(36'($signed(stg_q[i-1].a[j])),
                                         36'($signed(stg_q[i-1].ray[1].u[j]))));
            stg_d[i].prod[DOT_CD][j] = 64'(mul36(36'($signed(stg_q[i-1].c[j])),
                                         36'($signed(stg_q[i-1].ray[1].u[j]))));
            stg_d[i].prod[DOT_BD][j] = 64'(mul36(36'($signed(stg_q[i-1].ray[0].u[j])),
                                         36'($signed(stg_q[i-1].ray[1].u[j]))));
          end
        end
        if (i == ST_DOT) begin
          for (int p = 0; p < 5; p++) begin
            t72 = 72'($signed(stg_q[i-1].prod[p][0])) + 72'($signed(stg_q[i-1].prod[p][1])) +
                  72'($signed(stg_q[i-1].prod[p][2]));
            stg_d[i].dot[p] = 36'(rnd_shr(t72, 30));
          end
        end
        if (i == ST_QR) begin
          stg_d[i].qv = 35'(clamp_s(72'($signed(stg_q[i-1].dot[DOT_CB])) -
                                    72'($signed(stg_q[i-1].dot[DOT_AB])), PMAX));
          stg_d[i].rv = 35'(clamp_s(72'($signed(stg_q[i-1].dot[DOT_AD])) -
                                    72'($signed(stg_q[i-1].dot[DOT_CD])), PMAX));
          stg_d[i].bd = 32'(clamp_s(72'($signed(stg_q[i-1].dot[DOT_BD])), UNIT_ONE));
        end
        if (i == ST_MUL2) begin
          stg_d[i].bd2 = 64'(mul36(36'($signed(stg_q[i-1].bd)), 36'($signed(stg_q[i-1].bd))));
          stg_d[i].qbd = 67'(mul36(36'($signed(stg_q[i-1].qv)), 36'($signed(stg_q[i-1].bd))));
        end
        if (i == ST_NUM) begin
          t72 = (72'd1 << 60) - 72'(stg_q[i-1].bd2);
          stg_d[i].den = t72[60:0];
          stg_d[i].par = (t72 == 72'd0);
          stg_d[i].num = 36'(rnd_shr(72'($signed(stg_q[i-1].qbd)), 30) +
                             72'($signed(stg_q[i-1].rv)));
        end
        if (i == ST_SAT) begin
          // quotient above the parameter limit iff n * 2^27 >= den
          nm = stg_q[i-1].num[35] ? (~stg_q[i-1].num + 36'd1) : stg_q[i-1].num;
          stg_d[i].trem = {nm[34:0], 27'd0};
          stg_d[i].tsat = (stg_d[i].trem >= {1'b0, stg_q[i-1].den});
          stg_d[i].tneg = stg_q[i-1].num[35];
          stg_d[i].tquo = '0;
        end
        if (i >= ST_TD0 && i < ST_TD0 + TD_N) begin
          tr62 = {stg_q[i-1].trem[60:0], 1'b0};
          if (tr62 >= {1'b0, stg_q[i-1].den}) begin
            stg_d[i].trem = tr62 - {1'b0, stg_q[i-1].den};
            stg_d[i].tquo[32-TI] = 1'b1;
          end else begin
            stg_d[i].trem = tr62;
          end
        end
        if (i == ST_T) begin
          rb = ({stg_q[i-1].trem, 1'b0} >= {2'b00, stg_q[i-1].den});
          qq = {1'b0, stg_q[i-1].tquo} + 34'(!stg_q[i-1].tsat && rb);
          if (stg_q[i-1].tsat || qq > PMAX[33:0]) qq = PMAX[33:0];
          stg_d[i].tv = stg_q[i-1].tneg ? (~{1'b0, qq} + 35'd1) : {1'b0, qq};
        end
        if (i == ST_MUL3) begin
          stg_d[i].bdt = 67'(mul36(36'($signed(stg_q[i-1].bd)), 36'($signed(stg_q[i-1].tv))));
        end
        if (i == ST_S) begin
          stg_d[i].sv = 35'(clamp_s(rnd_shr(72'($signed(stg_q[i-1].bdt)), 30) +
                                    72'($signed(stg_q[i-1].qv)), PMAX));
        end
        if (i == ST_MUL4) begin
          for (int j = 0; j < 3; j++) begin
            stg_d[i].sb[j] = 67'(mul36(36'($signed(stg_q[i-1].sv)),
                                       36'($signed(stg_q[i-1].ray[0].u[j]))));
            stg_d[i].td[j] = 67'(mul36(36'($signed(stg_q[i-1].tv)),
                                       36'($signed(stg_q[i-1].ray[1].u[j]))));
          end
        end
        if (i == ST_MID) begin
          stg_d[i].deg = stg_q[i-1].ray[0].zero || stg_q[i-1].ray[1].zero || stg_q[i-1].par;
          for (int j = 0; j < 3; j++) begin
            t72 = 72'($signed(stg_q[i-1].a[j])) + 72'($signed(stg_q[i-1].c[j])) +
                  rnd_shr(72'($signed(stg_q[i-1].sb[j])), 30) +
                  rnd_shr(72'($signed(stg_q[i-1].td[j])), 30);
            h = rnd_shr(t72, 1);
            if ($signed(h) > POS_MAX) h = POS_MAX;
            if ($signed(h) < NEG_MIN) h = NEG_MIN;
            stg_d[i].mid[j] = stg_d[i].deg ? 32'd0 : h[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NST; i++) stg_q[i] <= stg_d[i];
    end
  end

  assign out_valid_o  = vld_q[NST-1];
  assign mid_x_o      = stg_q[NST-1].mid[0];
  assign mid_y_o      = stg_q[NST-1].mid[1];
  assign mid_z_o      = stg_q[NST-1].mid[2];
  assign degenerate_o = stg_q[NST-1].deg;

  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> mid_x_o == 32'd0 && mid_y_o == 32'd0 && mid_z_o == 32'd0)
    else $error("degenerate word with nonzero midpoint");

  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> out_valid_o == $past(vld_q[NST-2]))
    else $error("pipeline valid lost or duplicated");

  a_t_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_T] |-> $signed(72'($signed(stg_q[ST_T].tv))) <= PMAX &&
                    $signed(72'($signed(stg_q[ST_T].tv))) >= -PMAX)
    else $error("ray parameter outside saturation range");

endmodule

`default_nettype wire
